FILE: rtl/mbe_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time engine.
`timescale 1ns / 1ps
`default_nettype none
package mbe_pkg;

   localparam int FRAC_BITS = 28;
   localparam int OP_W      = 33;             // multiplier operand width
   localparam int PROD_W    = 2 * OP_W;       // multiplier product width
   localparam int SUM_W     = 48;             // headroom for adds before saturation
   localparam int SQ_W      = 35;             // (32-bit square) >> FRAC_BITS
   localparam int MAG_W     = SQ_W + 1;       // sum of two truncated squares

   // Fixed point landmarks in Q4.28
   localparam logic signed [31:0] FX_ONE     = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] FX_HALF    = 32'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [31:0] FX_QUARTER = 32'sd1 <<< (FRAC_BITS - 2);
   localparam logic [64:0]        DISC_LIM   = 65'd1 << (2 * FRAC_BITS - 4);

   // Register reset values
   localparam logic signed [31:0] LEFT_RE_RST    = -32'sd536870912;
   localparam logic signed [31:0] TOP_IM_RST     = 32'sd402653184;
   localparam logic [30:0]        STEP_RST       = 31'd786432;
   localparam logic [31:0]        BAILOUT_SQ_RST = 32'd1073741824;
   localparam logic [15:0]        MAX_ITER_RST   = 16'd256;

   typedef enum logic [2:0] {
      CSR_LEFT_RE    = 3'd0,
      CSR_TOP_IM     = 3'd1,
      CSR_STEP       = 3'd2,
      CSR_BAILOUT_SQ = 3'd3,
      CSR_MAX_ITER   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      EXTRA_NONE   = 2'd0,
      EXTRA_SECOND = 2'd1,
      EXTRA_FIRST  = 2'd2
   } extra_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP_RE,
      ST_MAP_IM,
      ST_POINT,
      ST_DISC_Y,
      ST_DISC_D,
      ST_CARD_A,
      ST_CARD_Q,
      ST_CARD_M,
      ST_CARD_T,
      ST_IT_RR,
      ST_IT_II,
      ST_IT_RI,
      ST_IT_UPD,
      ST_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
      lo = {{(SUM_W-31){1'b1}}, {31{1'b0}}};
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

FILE: rtl/mbe_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module mbe_mul (
   input  wire logic                                 clock,
   input  wire logic signed [mbe_pkg::OP_W-1:0]      op_a,
   input  wire logic signed [mbe_pkg::OP_W-1:0]      op_b,
   output logic signed      [mbe_pkg::PROD_W-1:0]    prod_ff
);
   import mbe_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

FILE: rtl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time pixel engine.
// Takes one pixel per transaction and returns one result per pixel. All
// multiplication runs through a single 33x33 multiplier with a registered
// product, stepped by a small sequencer, so the block handles one pixel at a
// time and req_ready is low while it works. The sequencer maps the pixel
// and then runs the disc and cardioid tests; a pixel found inside the disc
// or the cardioid is done without iterating. Each orbit iteration forms
// three products and then the update, and a last |z|^2 check plus the
// hand-off to the output register close the run. The sequencer returns to
// idle before it takes the next pixel. A finished result waits in the
// output register, and the next pixel is taken in the meantime; a second
// result waits in the sequencer until that register frees.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_time (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [9:0]  req_col,
   input  wire logic [9:0]  req_row,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [9:0]       rsp_out_col,
   output logic [9:0]       rsp_out_row,
   output logic             rsp_escaped,
   output logic [16:0]      rsp_iterations,
   output logic [63:0]      rsp_final_mag_sq,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import mbe_pkg::*;

   // configuration
   logic signed [31:0] left_re_ff, left_re_in;
   logic signed [31:0] top_im_ff, top_im_in;
   logic [30:0]        step_ff, step_in;
   logic [31:0]        bailout_ff, bailout_in;
   logic [15:0]        max_iter_ff, max_iter_in;

   // sequencer and working registers
   state_type          state_ff, state_in;
   logic [9:0]         col_ff, col_in;
   logic [9:0]         row_ff, row_in;
   logic signed [31:0] cr_ff, cr_in;
   logic signed [31:0] ci_ff, ci_in;
   logic signed [31:0] zr_ff, zr_in;
   logic signed [31:0] zi_ff, zi_in;
   logic [16:0]        cnt_ff, cnt_in;
   extra_type          extra_ff, extra_in;
   logic               esc_ff, esc_in;
   logic [63:0]        yy_ff, yy_in;
   logic [SQ_W-1:0]    re2_ff, re2_in;
   logic [SQ_W-1:0]    im2_ff, im2_in;
   logic [31:0]        q_ff, q_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         out_col_ff, out_col_in;
   logic [9:0]         out_row_ff, out_row_in;
   logic               out_esc_ff, out_esc_in;
   logic [16:0]        out_iter_ff, out_iter_in;
   logic [63:0]        out_mag_ff, out_mag_in;

   // multiplier
   logic signed [OP_W-1:0]   op_a, op_b;
   logic signed [PROD_W-1:0] prod;

   mbe_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   // datapath terms
   logic signed [SUM_W-1:0] map_re_sum, map_im_sum;
   logic [64:0]             reg_sum;
   logic                    in_disc, in_box, in_card;
   logic signed [OP_W-1:0]  cr_ext, ci_ext, zr_ext, zi_ext;
   logic signed [OP_W:0]    card_b;
   logic [SQ_W-1:0]         sq_now;
   logic [MAG_W-1:0]        mag_now;
   logic signed [37:0]      cross_prod;
   logic signed [SUM_W-1:0] ni_sum, nr_sum;
   logic                    slot_free, accept;

   assign cr_ext = {cr_ff[31], cr_ff};
   assign ci_ext = {ci_ff[31], ci_ff};
   assign zr_ext = {zr_ff[31], zr_ff};
   assign zi_ext = {zi_ff[31], zi_ff};

   assign map_re_sum = {{(SUM_W-32){left_re_ff[31]}}, left_re_ff}
                     + {{(SUM_W-42){1'b0}}, prod[41:0]};
   assign map_im_sum = {{(SUM_W-32){top_im_ff[31]}}, top_im_ff}
                     - {{(SUM_W-42){1'b0}}, prod[41:0]};

   assign reg_sum = {1'b0, prod[63:0]} + {1'b0, yy_ff};
   assign in_disc = reg_sum <= DISC_LIM;
   assign in_box  = (cr_ff >= -FX_ONE) && (cr_ff <= FX_HALF)
                 && (ci_ff >= -FX_ONE) && (ci_ff <= FX_ONE);
   // q + a; q stays below 2^30 inside the box so this fits the operand
   assign card_b  = {2'b00, q_ff} + {cr_ext[OP_W-1], cr_ext}
                  - {{(OP_W-30){1'b0}}, FX_QUARTER[30:0]};
   assign in_card = prod <= $signed({4'b0000, yy_ff[63:2]});

   assign sq_now     = prod[FRAC_BITS+SQ_W-1:FRAC_BITS];
   assign mag_now    = {1'b0, re2_ff} + {1'b0, sq_now};
   assign cross_prod = prod[PROD_W-1:FRAC_BITS];
   assign ni_sum     = {{(SUM_W-38){cross_prod[37]}}, cross_prod}
                     + {{(SUM_W-38){cross_prod[37]}}, cross_prod}
                     + {{(SUM_W-32){ci_ff[31]}}, ci_ff};
   assign nr_sum     = {{(SUM_W-SQ_W){1'b0}}, re2_ff} - {{(SUM_W-SQ_W){1'b0}}, im2_ff}
                     + {{(SUM_W-32){cr_ff[31]}}, cr_ff};

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MAP_RE;
         ST_MAP_RE: state_in = ST_MAP_IM;
         ST_MAP_IM: state_in = ST_POINT;
         ST_POINT:  state_in = ST_DISC_Y;
         ST_DISC_Y: state_in = ST_DISC_D;
         ST_DISC_D: state_in = ST_CARD_A;
         ST_CARD_A: state_in = in_disc ? ST_DONE : ST_CARD_Q;
         ST_CARD_Q: state_in = in_box ? ST_CARD_M : ST_IT_RR;
         ST_CARD_M: state_in = ST_CARD_T;
         ST_CARD_T: state_in = in_card ? ST_DONE : ST_IT_RR;
         ST_IT_RR:  state_in = ST_IT_II;
         ST_IT_II:  state_in = ST_IT_RI;
         ST_IT_RI: begin
            priority if (cnt_ff == '0) begin
               state_in = ST_IT_UPD;
            end else if (extra_ff == EXTRA_SECOND) begin
               state_in = ST_DONE;
            end else if (extra_ff == EXTRA_FIRST) begin
               state_in = ST_IT_UPD;
            end else if ({4'b0000, bailout_ff} <= mag_now) begin
               state_in = ST_IT_UPD;
            end else if (cnt_ff > {1'b0, max_iter_ff}) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_IT_UPD;
            end
         end
         ST_IT_UPD: state_in = ST_IT_RR;
         ST_DONE:   if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_a     = '0;
      op_b     = '0;
      col_in   = col_ff;
      row_in   = row_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      cnt_in   = cnt_ff;
      extra_in = extra_ff;
      esc_in   = esc_ff;
      yy_in    = yy_ff;
      re2_in   = re2_ff;
      im2_in   = im2_ff;
      q_in     = q_ff;
      mag_in   = mag_ff;

      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_esc_in  = out_esc_ff;
      out_iter_in = out_iter_ff;
      out_mag_in  = out_mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               col_in   = req_col;
               row_in   = req_row;
               zr_in    = '0;
               zi_in    = '0;
               cnt_in   = '0;
               extra_in = EXTRA_NONE;
               esc_in   = 1'b0;
            end
         end
         ST_MAP_RE: begin
            op_a = {{(OP_W-10){1'b0}}, col_ff};
            op_b = {{(OP_W-31){1'b0}}, step_ff};
         end
         ST_MAP_IM: begin
            cr_in = sat32(map_re_sum);
            op_a  = {{(OP_W-10){1'b0}}, row_ff};
            op_b  = {{(OP_W-31){1'b0}}, step_ff};
         end
         ST_POINT: begin
            ci_in = sat32(map_im_sum);
         end
         ST_DISC_Y: begin
            op_a = ci_ext;
            op_b = ci_ext;
         end
         ST_DISC_D: begin
            yy_in = prod[63:0];
            op_a  = cr_ext + {{(OP_W-32){1'b0}}, FX_ONE};
            op_b  = cr_ext + {{(OP_W-32){1'b0}}, FX_ONE};
         end
         ST_CARD_A: begin
            op_a = cr_ext - {{(OP_W-32){1'b0}}, FX_QUARTER};
            op_b = cr_ext - {{(OP_W-32){1'b0}}, FX_QUARTER};
         end
         ST_CARD_Q: begin
            q_in = reg_sum[FRAC_BITS+31:FRAC_BITS];
         end
         ST_CARD_M: begin
            op_a = {1'b0, q_ff};
            op_b = card_b[OP_W-1:0];
         end
         ST_CARD_T: begin
         end
         ST_IT_RR: begin
            op_a = zr_ext;
            op_b = zr_ext;
         end
         ST_IT_II: begin
            re2_in = sq_now;
            op_a   = zi_ext;
            op_b   = zi_ext;
         end
         ST_IT_RI: begin
            im2_in = sq_now;
            op_a   = zr_ext;
            op_b   = zi_ext;
            // |z|^2 here belongs to the z left by the last update
            if (cnt_ff != '0) begin
               priority if (extra_ff == EXTRA_SECOND) begin
                  mag_in = mag_now;
               end else if (extra_ff == EXTRA_FIRST) begin
                  extra_in = EXTRA_SECOND;
               end else if ({4'b0000, bailout_ff} <= mag_now) begin
                  extra_in = EXTRA_FIRST;
                  esc_in   = 1'b1;
               end else begin
               end
            end
         end
         ST_IT_UPD: begin
            zr_in  = sat32(nr_sum);
            zi_in  = sat32(ni_sum);
            cnt_in = cnt_ff + 17'd1;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_col_in   = col_ff;
               out_row_in   = row_ff;
               out_esc_in   = esc_ff;
               out_iter_in  = esc_ff ? cnt_ff : '0;
               out_mag_in   = esc_ff ? {{(64-MAG_W-(32-FRAC_BITS)){1'b0}}, mag_ff,
                                        {(32-FRAC_BITS){1'b0}}} : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // configuration writes
   always_comb begin
      left_re_in  = left_re_ff;
      top_im_in   = top_im_ff;
      step_in     = step_ff;
      bailout_in  = bailout_ff;
      max_iter_in = max_iter_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LEFT_RE:    left_re_in  = csr_wdata;
            CSR_TOP_IM:     top_im_in   = csr_wdata;
            CSR_STEP:       step_in     = csr_wdata[30:0];
            CSR_BAILOUT_SQ: bailout_in  = csr_wdata;
            CSR_MAX_ITER:   max_iter_in = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         left_re_ff   <= LEFT_RE_RST;
         top_im_ff    <= TOP_IM_RST;
         step_ff      <= STEP_RST;
         bailout_ff   <= BAILOUT_SQ_RST;
         max_iter_ff  <= MAX_ITER_RST;
         extra_ff     <= EXTRA_NONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         left_re_ff   <= left_re_in;
         top_im_ff    <= top_im_in;
         step_ff      <= step_in;
         bailout_ff   <= bailout_in;
         max_iter_ff  <= max_iter_in;
         extra_ff     <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      cnt_ff      <= cnt_in;
      esc_ff      <= esc_in;
      yy_ff       <= yy_in;
      re2_ff      <= re2_in;
      im2_ff      <= im2_in;
      q_ff        <= q_in;
      mag_ff      <= mag_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_esc_ff  <= out_esc_in;
      out_iter_ff <= out_iter_in;
      out_mag_ff  <= out_mag_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_col      = out_col_ff;
   assign rsp_out_row      = out_row_ff;
   assign rsp_escaped      = out_esc_ff;
   assign rsp_iterations   = out_iter_ff;
   assign rsp_final_mag_sq = out_mag_ff;

endmodule
`default_nettype wire

FILE: bench/tb_mandelbrot_escape_time.sv
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
`timescale 1ns / 1ps
module tb_mandelbrot_escape_time;
   import mbe_pkg::*;

   localparam longint FX_UNIT = 64'sd1 <<< FRAC_BITS;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam logic [63:0] Q32_SAT_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> (32 - FRAC_BITS);
   localparam logic [31:0] BAILOUT_FOUR = 32'h4000_0000;

   typedef struct {
      longint re;
      longint im;
   } orbit_type;

   typedef struct {
      logic [9:0]  col;
      logic [9:0]  row;
      logic        escaped;
      logic [16:0] iterations;
      logic [63:0] mag_sq;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [9:0]  req_col = '0;
   logic [9:0]  req_row = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [9:0]  rsp_out_col;
   logic [9:0]  rsp_out_row;
   logic        rsp_escaped;
   logic [16:0] rsp_iterations;
   logic [63:0] rsp_final_mag_sq;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = CSR_LEFT_RE;
   logic [31:0] csr_wdata = '0;

   // shadow copy of the register file
   longint cfg_left_re  = LEFT_RE_RST;
   longint cfg_top_im   = TOP_IM_RST;
   longint cfg_step     = STEP_RST;
   longint cfg_bailout  = BAILOUT_SQ_RST;
   longint cfg_max_iter = MAX_ITER_RST;

   pixel_result_type expected_pixels[$];
   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles    = 0;

   mandelbrot_escape_time dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_col          (req_col),
      .req_row          (req_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_row      (rsp_out_row),
      .rsp_escaped      (rsp_escaped),
      .rsp_iterations   (rsp_iterations),
      .rsp_final_mag_sq (rsp_final_mag_sq),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #50_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp32(input longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   function automatic longint unsigned square_mag(input longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      return m * m;
   endfunction

   function automatic bit in_disc(input longint x, input longint y);
      return (square_mag(x + FX_UNIT) + square_mag(y)) <= (64'd1 << (2 * FRAC_BITS - 4));
   endfunction

   function automatic bit in_cardioid(input longint x, input longint y);
      longint a;
      longint q;
      if (x < -FX_UNIT || x > FX_UNIT / 2 || y < -FX_UNIT || y > FX_UNIT) return 1'b0;
      a = x - FX_UNIT / 4;
      q = longint'((square_mag(a) + square_mag(y)) >> FRAC_BITS);
      return q * (q + a) <= longint'(square_mag(y) >> 2);
   endfunction

   function automatic orbit_type advance_orbit(input orbit_type z, input orbit_type c);
      orbit_type nz;
      longint re2;
      longint im2;
      longint cross_term;
      re2        = longint'(square_mag(z.re) >> FRAC_BITS);
      im2        = longint'(square_mag(z.im) >> FRAC_BITS);
      cross_term = (z.re * z.im) >>> FRAC_BITS;
      nz.im = clamp32(2 * cross_term + c.im);
      nz.re = clamp32(re2 - im2 + c.re);
      return nz;
   endfunction

   function automatic longint unsigned orbit_mag(input orbit_type z);
      return (square_mag(z.re) >> FRAC_BITS) + (square_mag(z.im) >> FRAC_BITS);
   endfunction

   function automatic pixel_result_type compute_pixel(input logic [9:0] col,
                                                      input logic [9:0] row);
      pixel_result_type res;
      orbit_type point;
      orbit_type z;
      longint unsigned mag;
      int unsigned count;
      bit escaped;
      point.re = clamp32(cfg_left_re + longint'(col) * cfg_step);
      point.im = clamp32(cfg_top_im - longint'(row) * cfg_step);
      z.re = 0;
      z.im = 0;
      count = 0;
      escaped = 1'b0;
      if (!in_disc(point.re, point.im) && !in_cardioid(point.re, point.im)) begin
         do begin
            z = advance_orbit(z, point);
            mag = orbit_mag(z);
            count++;
            escaped = (mag >= cfg_bailout);
         end while (!escaped && count <= cfg_max_iter);
      end
      res.col = col;
      res.row = row;
      res.escaped = escaped;
      res.iterations = '0;
      res.mag_sq = '0;
      if (escaped) begin
         z = advance_orbit(z, point);
         z = advance_orbit(z, point);
         mag = orbit_mag(z);
         res.iterations = 17'(count + 2);
         res.mag_sq = (mag > Q32_SAT_LIMIT) ? 64'hFFFF_FFFF_FFFF_FFFF
                                            : mag << (32 - FRAC_BITS);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string tag, input string name,
                              input logic [63:0] got, input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s %s: got %0h, want %0h", tag, name, got, want));
   endtask

   task automatic check_pixel_result();
      pixel_result_type want;
      string tag;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("result for pixel (%0d,%0d) with nothing outstanding",
                                   rsp_out_col, rsp_out_row));
         return;
      end
      want = expected_pixels.pop_front();
      tag = $sformatf("pixel (%0d,%0d)", want.col, want.row);
      check_field(tag, "out_col", rsp_out_col, want.col);
      check_field(tag, "out_row", rsp_out_row, want.row);
      check_field(tag, "escaped", rsp_escaped, want.escaped);
      check_field(tag, "iterations", rsp_iterations, want.iterations);
      check_field(tag, "final_mag_sq", rsp_final_mag_sq, want.mag_sq);
   endtask

   // result side: check each transaction, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_pixel_result();
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] left, input logic [31:0] top,
                            input logic [30:0] pitch, input logic [31:0] bailout,
                            input logic [15:0] limit);
      write_reg(CSR_LEFT_RE, left);
      write_reg(CSR_TOP_IM, top);
      write_reg(CSR_STEP, {1'b0, pitch});
      write_reg(CSR_BAILOUT_SQ, bailout);
      write_reg(CSR_MAX_ITER, {16'd0, limit});
      csr_wr_en <= 1'b0;
      cfg_left_re  = longint'(signed'(left));
      cfg_top_im   = longint'(signed'(top));
      cfg_step     = pitch;
      cfg_bailout  = bailout;
      cfg_max_iter = limit;
   endtask

   // valid is left high on return; the next call or wait_idle decides its fate
   task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_col   <= col;
      req_row   <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_pixels.push_back(compute_pixel(col, row));
   endtask

   task automatic send_random_pixel();
      send_pixel(10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // window of 1024x1024 pixels centered on a chosen point, mostly near the set boundary
   task automatic random_view_config(input logic [15:0] limit);
      longint cx;
      longint cy;
      longint pitch;
      logic [31:0] bailout;
      case ($urandom_range(4, 0))
         0: begin cx = -201326592; cy = 26843546;  end  // -0.75 + 0.1i
         1: begin cx = -335544320; cy = 0;         end  // -1.25
         2: begin cx = 75161928;   cy = 2684355;   end  // 0.28 + 0.01i
         3: begin cx = -26843546;  cy = 241591910; end  // -0.1 + 0.9i
         default: begin cx = -134217728; cy = 0;   end  // whole set
      endcase
      pitch = $urandom_range(1 << 20, 1 << 10);
      bailout = ($urandom_range(3, 0) != 0) ? BAILOUT_FOUR : $urandom();
      configure(32'(cx - 512 * pitch), 32'(cy + 512 * pitch), 31'(pitch), bailout, limit);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_default_view();
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd512);
      send_pixel(10'd171, 10'd512);
   endtask

   // c = -2 + col/16 + i(1 - row/16)
   task automatic test_region_tests();
      wait_idle();
      configure(32'hE000_0000, 32'h1000_0000, 31'h0100_0000, BAILOUT_FOUR, 16'd64);
      send_pixel(10'd16, 10'd16);     // disc center
      send_pixel(10'd12, 10'd16);     // disc rim, counts as inside
      send_pixel(10'd11, 10'd16);     // just outside disc, bounded orbit
      send_pixel(10'd32, 10'd16);     // origin, cardioid
      send_pixel(10'd36, 10'd16);     // cardioid cusp
      send_pixel(10'd37, 10'd16);     // past the cusp, slow escape
      send_pixel(10'd32, 10'd0);      // c = i, runs to the limit
      send_pixel(10'd0, 10'd16);      // c = -2, hits bailout exactly
      send_pixel(10'd1023, 10'd1023); // both parts saturate
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd1023);
   endtask

   task automatic test_zero_settings();
      wait_idle();
      configure(32'h0, FX_ONE, 31'd0, 32'd0, 16'd0);
      send_pixel(10'd5, 10'd7);
      send_pixel(10'd1023, 10'd1023);
      wait_idle();
      configure(32'h0, FX_ONE, 31'd0, BAILOUT_FOUR, 16'd0);
      send_pixel(10'd0, 10'd0);
   endtask

   task automatic test_saturation();
      wait_idle();
      configure(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      wait_idle();
      configure(32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 32'hFFFF_FFFF, 16'hFFFF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
   endtask

   // c = i has a periodic orbit and never escapes, so it runs to the iteration limit
   task automatic test_longest_limit();
      wait_idle();
      configure(32'h0, FX_ONE, 31'd1, BAILOUT_FOUR, 16'hFFFF);
      send_pixel(10'd0, 10'd0);
   endtask

   task automatic test_random_pixels();
      int send_pct[4] = '{0, 61, 0, 14};
      int recv_pct[4] = '{0, 0, 61, 14};
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_pct[phase];
         recv_stall_pct = recv_pct[phase];
         for (int setting = 0; setting < 5; setting++) begin
            wait_idle();
            if (setting == 4)
               configure($urandom(), $urandom(), 31'($urandom_range(32'h7FFF_FFFF, 0)),
                         $urandom(), 16'($urandom_range(63, 0)));
            else
               random_view_config(16'($urandom_range(48, 1)));
            repeat (55) send_random_pixel();
         end
      end
   endtask

   // receiver goes quiet long enough for the engine and its output stage to fill
   task automatic test_output_backpressure();
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_view_config(16'd8);
      hold_cycles = 400;
      repeat (12) send_random_pixel();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_default_view();
      test_region_tests();
      test_zero_settings();
      test_saturation();
      test_longest_limit();
      test_random_pixels();
      test_output_backpressure();
      wait_idle();
      repeat (64) @(posedge clock);
      if (expected_pixels.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
